@@ sv/segbox_pkg.sv @@
// Shared constants for the segment versus box slab test.
// No dependencies; imported by segment_box_slab_intersect.
`default_nettype none
package segbox_pkg;
	localparam int N_AXES  = 3;
	localparam int N_LANES = 2 * N_AXES;   // min and max plane of each axis
	localparam int FRAC_W  = 32;           // width of a fraction result
	localparam int QBITS   = FRAC_W - 1;   // quotient magnitude bits
	localparam int OUT_W   = 72;           // hit + two fractions, byte padded
	localparam logic signed [FRAC_W-1:0] FR_MAX = {1'b0, {(FRAC_W-1){1'b1}}};
	localparam logic signed [FRAC_W-1:0] FR_MIN = {1'b1, {(FRAC_W-1){1'b0}}};
endpackage
`default_nettype wire

@@ sv/segment_box_slab_intersect.sv @@
// Segment versus axis-aligned box intersection, slab method, fixed point.
// Depends on segbox_pkg (lane counts, fraction width, saturation limits).
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   box min xyz, box max xyz, start xyz, end xyz
// m_*      out  m_tvalid/m_tready   hit, near_fraction, far_fraction
//
// One request enters per cycle while the output register is empty or taken.
// Stages: 1, 2, divider entry, divider stages, 4, 5, output register. Depth is
// set by the six restoring dividers, which resolve one quotient bit per stage.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipeline advances whenever the output register is empty or taken,
// so a stall holds every stage in place and nothing is lost or repeated.
`default_nettype none
module segment_box_slab_intersect
	import segbox_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// from bit 0: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
	// start_x, start_y, start_z, end_x, end_y, end_z (COORD_BITS each), zero pad
	input  wire logic [((12*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// from bit 0: hit (1), near_fraction (32), far_fraction (32), zero pad (7)
	output logic [OUT_W-1:0] m_tdata
);
	localparam int NW = COORD_BITS + 1;      // coordinate difference width
	localparam int RW = COORD_BITS + 33;     // divider remainder width
	localparam int SATSH = QBITS - FRAC_BITS;
	localparam logic signed [FRAC_W-1:0] ONE = FRAC_W'(1) << FRAC_BITS;

	logic ce;
	assign ce = !m_tvalid || m_tready;
	assign s_tready = ce;

	// ---- stage 1: sign extend, form differences from the start point ----
	logic v_s1;
	logic signed [NW-1:0] num_s1 [N_LANES];
	logic signed [NW-1:0] d_s1 [N_AXES];
	logic signed [NW-1:0] num_c [N_LANES];
	logic signed [NW-1:0] d_c [N_AXES];

	always_comb begin
		for (int a = 0; a < N_AXES; a++) begin
			logic signed [NW-1:0] lo, hi, p0, p1;
			lo = NW'($signed(s_tdata[a*COORD_BITS +: COORD_BITS]));
			hi = NW'($signed(s_tdata[(3+a)*COORD_BITS +: COORD_BITS]));
			p0 = NW'($signed(s_tdata[(6+a)*COORD_BITS +: COORD_BITS]));
			p1 = NW'($signed(s_tdata[(9+a)*COORD_BITS +: COORD_BITS]));
			num_c[2*a]   = lo - p0;
			num_c[2*a+1] = hi - p0;
			d_c[a]       = p1 - p0;
		end
	end

	// ---- stage 2: magnitudes, quotient signs, zero-extent axis test ----
	logic v_s2;
	logic [NW-1:0] un_s2 [N_LANES];
	logic [NW-1:0] ud_s2 [N_AXES];
	logic neg_s2 [N_LANES];
	logic dz_s2 [N_AXES];
	logic zmiss_s2 [N_AXES];

	// ---- divider stages: index 0 is entry, index k resolves bit QBITS-k ----
	logic v_sd [0:QBITS];
	logic [RW-1:0] rem_sd [0:QBITS][N_LANES];
	logic [QBITS-1:0] q_sd [0:QBITS][N_LANES];
	logic [NW-1:0] ud_sd [0:QBITS][N_AXES];
	logic sat_sd [0:QBITS][N_LANES];
	logic neg_sd [0:QBITS][N_LANES];
	logic dz_sd [0:QBITS][N_AXES];
	logic zmiss_sd [0:QBITS][N_AXES];

	// ---- stage 4: signed, ordered fractions; stage 5: near/far fold ----
	logic v_s4, v_s5;
	logic signed [FRAC_W-1:0] t0_s4 [N_AXES];
	logic signed [FRAC_W-1:0] t1_s4 [N_AXES];
	logic dz_s4 [N_AXES];
	logic miss_s4;
	logic signed [FRAC_W-1:0] near_s5, far_s5;
	logic miss_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s4 <= v_sd[QBITS];
			v_s5 <= v_s4;
			m_tvalid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			num_s1 <= num_c;
			d_s1 <= d_c;
			for (int a = 0; a < N_AXES; a++) begin
				ud_s2[a] <= d_s1[a][NW-1] ? NW'(-d_s1[a]) : NW'(d_s1[a]);
				dz_s2[a] <= (d_s1[a] == '0);
				// start below min (lo - p0 > 0) or above max (hi - p0 < 0)
				zmiss_s2[a] <= (d_s1[a] == '0)
					&& ((!num_s1[2*a][NW-1] && num_s1[2*a] != '0) || num_s1[2*a+1][NW-1]);
			end
			for (int l = 0; l < N_LANES; l++) begin
				un_s2[l] <= num_s1[l][NW-1] ? NW'(-num_s1[l]) : NW'(num_s1[l]);
				neg_s2[l] <= num_s1[l][NW-1] ^ d_s1[l/2][NW-1];
			end
		end
	end

	// divider entry: saturation check and dividend load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (ce) begin
			v_sd[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int a = 0; a < N_AXES; a++) begin
				ud_sd[0][a] <= ud_s2[a];
				dz_sd[0][a] <= dz_s2[a];
				zmiss_sd[0][a] <= zmiss_s2[a];
			end
			for (int l = 0; l < N_LANES; l++) begin
				rem_sd[0][l] <= RW'(un_s2[l]) << FRAC_BITS;
				q_sd[0][l] <= '0;
				sat_sd[0][l] <= (RW'(un_s2[l]) >= (RW'(ud_s2[l/2]) << SATSH));
				neg_sd[0][l] <= neg_s2[l];
			end
		end
	end

	for (genvar k = 1; k <= QBITS; k++) begin : g_div
		localparam int B = QBITS - k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else if (ce) begin
				v_sd[k] <= v_sd[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				for (int a = 0; a < N_AXES; a++) begin
					ud_sd[k][a] <= ud_sd[k-1][a];
					dz_sd[k][a] <= dz_sd[k-1][a];
					zmiss_sd[k][a] <= zmiss_sd[k-1][a];
				end
				for (int l = 0; l < N_LANES; l++) begin
					logic [RW-1:0] dsh;
					logic [QBITS-1:0] qn;
					dsh = RW'(ud_sd[k-1][l/2]) << B;
					qn = q_sd[k-1][l];
					if (rem_sd[k-1][l] >= dsh) begin
						rem_sd[k][l] <= rem_sd[k-1][l] - dsh;
						qn[B] = 1'b1;
					end else begin
						rem_sd[k][l] <= rem_sd[k-1][l];
					end
					q_sd[k][l] <= qn;
					sat_sd[k][l] <= sat_sd[k-1][l];
					neg_sd[k][l] <= neg_sd[k-1][l];
				end
			end
		end
	end

	// apply sign and saturation, order each axis pair
	logic signed [FRAC_W-1:0] t_c [N_LANES];
	always_comb begin
		for (int l = 0; l < N_LANES; l++) begin
			logic [FRAC_W-1:0] mag;
			mag = {1'b0, q_sd[QBITS][l]};
			if (sat_sd[QBITS][l]) begin
				t_c[l] = neg_sd[QBITS][l] ? FR_MIN : FR_MAX;
			end else begin
				t_c[l] = neg_sd[QBITS][l] ? $signed(~mag + 1'b1) : $signed(mag);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			miss_s4 <= zmiss_sd[QBITS][0] || zmiss_sd[QBITS][1] || zmiss_sd[QBITS][2];
			for (int a = 0; a < N_AXES; a++) begin
				dz_s4[a] <= dz_sd[QBITS][a];
				if (t_c[2*a] > t_c[2*a+1]) begin
					t0_s4[a] <= t_c[2*a+1];
					t1_s4[a] <= t_c[2*a];
				end else begin
					t0_s4[a] <= t_c[2*a];
					t1_s4[a] <= t_c[2*a+1];
				end
			end
		end
	end

	// fold near maximum and far minimum over axes with nonzero extent
	logic signed [FRAC_W-1:0] near_c, far_c;
	always_comb begin
		near_c = FR_MIN;
		far_c = FR_MAX;
		for (int a = 0; a < N_AXES; a++) begin
			if (!dz_s4[a]) begin
				if (t0_s4[a] > near_c) near_c = t0_s4[a];
				if (t1_s4[a] < far_c) far_c = t1_s4[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			near_s5 <= near_c;
			far_s5 <= far_c;
			miss_s5 <= miss_s4;
		end
	end

	// final range checks into the output register
	logic hit_c;
	assign hit_c = !miss_s5 && !(near_s5 > far_s5) && !far_s5[FRAC_W-1] && !(near_s5 > ONE);

	always_ff @(posedge clk) begin
		if (ce) begin
			m_tdata <= {7'd0,
				hit_c ? far_s5 : '0,
				hit_c ? near_s5 : '0,
				hit_c};
		end
	end
endmodule
`default_nettype wire
